### rtl/core/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest block.
// No dependencies; imported by the core, the compression unit and the checker.
package sha1md_pkg;

  // Initial chaining value
  localparam logic [31:0] IV_H0 = 32'h67452301;
  localparam logic [31:0] IV_H1 = 32'hEFCDAB89;
  localparam logic [31:0] IV_H2 = 32'h98BADCFE;
  localparam logic [31:0] IV_H3 = 32'h10325476;
  localparam logic [31:0] IV_H4 = 32'hC3D2E1F0;

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] K_GROUP0 = 32'h5A827999;
  localparam logic [31:0] K_GROUP1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_GROUP2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_GROUP3 = 32'hCA62C1D6;

  localparam int unsigned ROUNDS     = 80;
  localparam logic [6:0]  LAST_ROUND = 7'(ROUNDS - 1);
  localparam logic [7:0]  PAD_MARKER = 8'h80;
  localparam logic [5:0]  LEN_START  = 6'd56;
  localparam int unsigned NUM_WORDS  = 5;
  localparam logic [2:0]  LAST_INDEX = 3'(NUM_WORDS - 1);

  // Five 32-bit chaining words, word 0 most significant
  typedef logic [NUM_WORDS-1:0][31:0] chain_t;

  // Commands from the sequencer to the compression unit
  typedef struct packed {
    logic       shift;   // shift one byte into the block buffer
    logic [7:0] data;    // byte to shift in
    logic       start;   // begin 80 rounds on the buffered block
    logic       reinit;  // restore the initial chaining value
  } sha1md_ctrl_t;

endpackage

### rtl/core/sha1_message_digest.sv
// Streaming SHA-1 digest: byte intake, padding sequencer and digest output.
// Depends on sha1md_pkg and sha1md_compress.
// Throughput: one byte per cycle; after every 64th byte the input stalls for 80 rounds
//   of the shared round unit and a chaining add, then reopens.
// End of message: pad bytes up to the next 64-byte boundary (9 to 72), each padded block
//   compressed in turn, then five digest words, one per cycle unless out_stall_i holds them.
// Reset: asynchronous, active low; returns to idle with the initial hash value.
module sha1_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  message_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha1md_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_COMP = 4'b0010,
    S_PAD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e       state_q, state_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  total_q, total_d;
  logic         marker_q, marker_d;
  logic [2:0]   len_cnt_q, len_cnt_d;
  logic         len_done_q, len_done_d;
  logic         final_q, final_d;
  logic [2:0]   idx_q, idx_d;

  sha1md_ctrl_t ctrl;
  logic         comp_busy;
  chain_t       chain;

  logic         in_xfer, out_xfer, in_len;
  logic [63:0]  bit_len;
  logic [2:0]   len_sel;
  logic [7:0]   len_byte, pad_byte;

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign out_xfer = out_valid_o & ~out_stall_i;

  // Pick the next pad byte: marker, zero fill, then the big-endian bit length
  assign bit_len  = {total_q, 3'b000};
  assign len_sel  = 3'd7 - len_cnt_q;
  assign len_byte = bit_len[{len_sel, 3'b000} +: 8];
  assign in_len   = (fill_q == LEN_START) || (len_cnt_q != 3'd0);
  assign pad_byte = !marker_q ? PAD_MARKER : (in_len ? len_byte : 8'h00);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    total_d     = total_q;
    marker_d    = marker_q;
    len_cnt_d   = len_cnt_q;
    len_done_d  = len_done_q;
    final_d     = final_q;
    idx_d       = idx_q;
    ctrl.shift  = 1'b0;
    ctrl.data   = message_byte_i;
    ctrl.start  = 1'b0;
    ctrl.reinit = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (byte_present_i) begin
            ctrl.shift = 1'b1;
            fill_d     = fill_q + 6'd1;
            total_d    = total_q + 61'd1;
          end
          if (end_of_message_i) begin
            final_d = 1'b1;
          end
          if (byte_present_i && fill_q == 6'd63) begin
            ctrl.start = 1'b1;
            state_d    = S_COMP;
          end else if (end_of_message_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        ctrl.shift = 1'b1;
        ctrl.data  = pad_byte;
        fill_d     = fill_q + 6'd1;
        marker_d   = 1'b1;
        if (marker_q && in_len) begin
          len_cnt_d = len_cnt_q + 3'd1;
          if (len_cnt_q == 3'd7) begin
            len_done_d = 1'b1;
          end
        end
        if (fill_q == 6'd63) begin
          ctrl.start = 1'b1;
          state_d    = S_COMP;
        end
      end
      S_COMP: begin
        if (!comp_busy) begin
          if (!final_q) begin
            state_d = S_IDLE;
          end else if (len_done_q) begin
            state_d = S_OUT;
          end else begin
            state_d = S_PAD;
          end
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          if (idx_q == LAST_INDEX) begin
            idx_d       = '0;
            ctrl.reinit = 1'b1;
            fill_d      = '0;
            total_d     = '0;
            marker_d    = 1'b0;
            len_cnt_d   = '0;
            len_done_d  = 1'b0;
            final_d     = 1'b0;
            state_d     = S_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      total_q    <= '0;
      marker_q   <= 1'b0;
      len_cnt_q  <= '0;
      len_done_q <= 1'b0;
      final_q    <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      total_q    <= total_d;
      marker_q   <= marker_d;
      len_cnt_q  <= len_cnt_d;
      len_done_q <= len_done_d;
      final_q    <= final_d;
      idx_q      <= idx_d;
    end
  end

  sha1md_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .busy_o  (comp_busy),
    .chain_o (chain)
  );

  // Ports
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign digest_word_o = chain[LAST_INDEX - idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == LAST_INDEX);

endmodule

### rtl/core/sha1md_compress.sv
// SHA-1 compression unit: block buffer, message schedule, one round per cycle.
// Depends on sha1md_pkg.
module sha1md_compress (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha1md_pkg::sha1md_ctrl_t ctrl_i,
  output logic                 busy_o,
  output sha1md_pkg::chain_t   chain_o
);
  import sha1md_pkg::*;

  logic [15:0][31:0] sched_q, sched_d;
  logic [4:0][31:0]  regs_q, regs_d;
  chain_t            chain_q, chain_d;
  logic [6:0]        round_q, round_d;
  logic              run_q, run_d;
  logic              fin_q, fin_d;

  logic [31:0] mix, wt, fv, kv, tmp;
  logic [31:0] ra, rb, rc, rd, re;

  assign ra = regs_q[0];
  assign rb = regs_q[1];
  assign rc = regs_q[2];
  assign rd = regs_q[3];
  assign re = regs_q[4];

  // Schedule word: buffered words first, then the expanded recurrence
  assign mix = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
  assign wt  = (round_q < 7'd16) ? sched_q[0] : {mix[30:0], mix[31]};

  // Round function and constant by round group
  always_comb begin
    if (round_q < 7'd20) begin
      fv = (rb & rc) | (~rb & rd);
      kv = K_GROUP0;
    end else if (round_q < 7'd40) begin
      fv = rb ^ rc ^ rd;
      kv = K_GROUP1;
    end else if (round_q < 7'd60) begin
      fv = (rb & rc) | (rb & rd) | (rc & rd);
      kv = K_GROUP2;
    end else begin
      fv = rb ^ rc ^ rd;
      kv = K_GROUP3;
    end
  end

  assign tmp = {ra[26:0], ra[31:27]} + fv + re + kv + wt;

  // Buffer: shift in bytes big-endian, or rotate the schedule window per round
  always_comb begin
    sched_d = sched_q;
    if (ctrl_i.shift) begin
      for (int i = 0; i < 15; i++) begin
        sched_d[i] = {sched_q[i][23:0], sched_q[i+1][31:24]};
      end
      sched_d[15] = {sched_q[15][23:0], ctrl_i.data};
    end else if (run_q) begin
      for (int i = 0; i < 15; i++) begin
        sched_d[i] = sched_q[i+1];
      end
      sched_d[15] = wt;
    end
  end

  // Working registers a..e; chain index 4 holds word 0, which seeds a
  always_comb begin
    regs_d = regs_q;
    if (ctrl_i.start) begin
      regs_d = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
    end else if (run_q) begin
      regs_d[0] = tmp;
      regs_d[1] = ra;
      regs_d[2] = {rb[1:0], rb[31:2]};
      regs_d[3] = rc;
      regs_d[4] = rd;
    end
  end

  // Round sequencer and chaining update
  always_comb begin
    round_d = round_q;
    run_d   = run_q;
    fin_d   = 1'b0;
    chain_d = chain_q;
    if (ctrl_i.start) begin
      round_d = '0;
      run_d   = 1'b1;
    end else if (run_q) begin
      round_d = round_q + 7'd1;
      if (round_q == LAST_ROUND) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end
    end
    if (fin_q) begin
      chain_d[4] = chain_q[4] + ra;
      chain_d[3] = chain_q[3] + rb;
      chain_d[2] = chain_q[2] + rc;
      chain_d[1] = chain_q[1] + rd;
      chain_d[0] = chain_q[0] + re;
    end
    if (ctrl_i.reinit) begin
      chain_d = {IV_H0, IV_H1, IV_H2, IV_H3, IV_H4};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= '0;
      run_q   <= 1'b0;
      fin_q   <= 1'b0;
      chain_q <= {IV_H0, IV_H1, IV_H2, IV_H3, IV_H4};
    end else begin
      round_q <= round_d;
      run_q   <= run_d;
      fin_q   <= fin_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sched_q <= sched_d;
    regs_q  <= regs_d;
  end

  assign busy_o  = run_q | fin_q;
  assign chain_o = chain_q;

endmodule

### rtl/core/sha1md_checker.sv
// Port-level checks for the SHA-1 message digest block, bound to the top level.
// Depends on sha1md_pkg and sha1_message_digest.
module sha1md_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);
  import sha1md_pkg::*;

  // Hold a stalled digest word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o)))
    else $error("stalled digest word changed");

  // Mark only the final word as last
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == LAST_INDEX)))
    else $error("last_word does not match word_index");

  // Take no input while digest words are pending
  a_no_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during digest output");

  // Advance the word index by one on each transfer before the last word
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_word_o) |=>
      (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest word index skipped");

  // Drop the output after the last word and reopen the input
  a_end_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> (!out_valid_o && !in_stall_o))
    else $error("digest did not end after the last word");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digest_word_o (digest_word_o),
  .word_index_o  (word_index_o),
  .last_word_o   (last_word_o)
);
